### rtl/lbpg_pkg.sv
// ----------------------------------------------------------------------------
// lbpg_pkg
// Shared types, constants and helpers for the LED breathing pattern generator.
// ----------------------------------------------------------------------------
package lbpg_pkg;

   // Pattern numbers and register file
   localparam int PAT_BITS       = 3;
   localparam int NUM_PATTERNS   = 4;
   localparam int NUM_WORDS      = 4;
   localparam int WORD_IDX_BITS  = $clog2(NUM_WORDS);
   localparam int WORD_BITS      = 64;
   localparam int CSR_INDEX_BITS = 3;

   // Pattern word layout
   localparam int TIME_BITS = 24;
   localparam int HIGH_LSB  = 24;
   localparam int STEP_LSB  = 48;
   localparam int RATE_LSB  = 56;
   localparam int BYTE_BITS = 8;

   // Duty
   localparam int DUTY_BITS = 7;
   localparam logic [DUTY_BITS-1:0] FULL_DUTY = DUTY_BITS'(100);
   localparam logic [DUTY_BITS-1:0] ZERO_DUTY = '0;

   localparam logic [PAT_BITS-1:0] NO_PATTERN = PAT_BITS'(4);

   typedef enum logic [1:0] {
      PHASE_LOW  = 2'd0,
      PHASE_RISE = 2'd1,
      PHASE_HIGH = 2'd2,
      PHASE_FALL = 2'd3
   } phase_type;

   // Sequencer state, including the registers that drive the outputs
   typedef struct packed {
      phase_type                phase;
      logic [DUTY_BITS-1:0]     duty;
      logic [TIME_BITS-1:0]     wait_count;
      logic [PAT_BITS-1:0]      last_pattern;
      logic [DUTY_BITS-1:0]     shown_level;
      phase_type                shown_phase;
   } state_type;

   // A wait of T ticks: zero or one lets the next tick act
   function automatic logic [TIME_BITS-1:0] wait_for(input logic [TIME_BITS-1:0] t);
      return (t == '0) ? '0 : t - TIME_BITS'(1);
   endfunction

endpackage

### rtl/lbpg_step.sv
// ----------------------------------------------------------------------------
// lbpg_step
// One tick of the breathing sequencer: next state from current state, tick
// pattern number and that pattern's word.
// ----------------------------------------------------------------------------
module lbpg_step (
   input  lbpg_pkg::state_type                 cur,
   input  logic [lbpg_pkg::PAT_BITS-1:0]       pattern,
   input  logic [lbpg_pkg::WORD_BITS-1:0]      word,
   output lbpg_pkg::state_type                 nxt
);
   import lbpg_pkg::*;

   logic [TIME_BITS-1:0] low_t;
   logic [TIME_BITS-1:0] high_t;
   logic [TIME_BITS-1:0] step_t;
   logic [BYTE_BITS-1:0] rate;
   logic                 waiting;
   logic                 restart;
   logic                 pat_valid;
   phase_type            base_phase;
   logic [DUTY_BITS-1:0] base_duty;
   logic [BYTE_BITS:0]   rise_sum;
   logic                 rise_full;
   logic [DUTY_BITS-1:0] rise_duty;
   logic [BYTE_BITS-1:0] fall_diff;
   logic [DUTY_BITS-1:0] fall_duty;

   assign low_t  = word[TIME_BITS-1:0];
   assign high_t = word[HIGH_LSB +: TIME_BITS];
   assign step_t = TIME_BITS'(word[STEP_LSB +: BYTE_BITS]);
   assign rate   = word[RATE_LSB +: BYTE_BITS];

   assign waiting    = (cur.wait_count != '0);
   assign restart    = (pattern != cur.last_pattern);
   assign pat_valid  = (pattern < PAT_BITS'(NUM_PATTERNS));
   assign base_phase = restart ? PHASE_LOW : cur.phase;
   assign base_duty  = restart ? ZERO_DUTY : cur.duty;

   // rise saturates at full duty, fall saturates at zero
   assign rise_sum  = (BYTE_BITS+1)'(base_duty) + (BYTE_BITS+1)'(rate);
   assign rise_full = (rise_sum >= (BYTE_BITS+1)'(FULL_DUTY));
   assign rise_duty = rise_full ? FULL_DUTY : rise_sum[DUTY_BITS-1:0];
   assign fall_diff = BYTE_BITS'(base_duty) - rate;
   assign fall_duty = (BYTE_BITS'(base_duty) > rate) ? fall_diff[DUTY_BITS-1:0]
                                                     : ZERO_DUTY;

   always_comb begin
      // next state: phase, duty, sampled pattern
      nxt.phase        = cur.phase;
      nxt.duty         = cur.duty;
      nxt.last_pattern = cur.last_pattern;
      if (!waiting) begin
         nxt.last_pattern = pattern;
         nxt.phase        = base_phase;
         nxt.duty         = base_duty;
         if (pat_valid) begin
            case (base_phase)
               PHASE_LOW: begin
                  nxt.phase = PHASE_RISE;
               end
               PHASE_RISE: begin
                  nxt.duty = rise_duty;
                  if (rise_full) nxt.phase = PHASE_HIGH;
               end
               PHASE_HIGH: begin
                  nxt.phase = PHASE_FALL;
               end
               PHASE_FALL: begin
                  nxt.duty = fall_duty;
                  if (fall_duty == ZERO_DUTY) nxt.phase = PHASE_LOW;
               end
               default: begin
                  nxt.phase = PHASE_LOW;
               end
            endcase
         end
      end

      // outputs of the step: shown level and phase, wait reload
      nxt.shown_level = cur.shown_level;
      nxt.shown_phase = cur.shown_phase;
      nxt.wait_count  = waiting ? cur.wait_count - TIME_BITS'(1) : cur.wait_count;
      if (!waiting && pat_valid) begin
         nxt.shown_phase = base_phase;
         case (base_phase)
            PHASE_LOW: begin
               nxt.shown_level = ZERO_DUTY;
               nxt.wait_count  = wait_for(low_t);
            end
            PHASE_RISE: begin
               nxt.shown_level = rise_duty;
               nxt.wait_count  = wait_for(step_t);
            end
            PHASE_HIGH: begin
               nxt.shown_level = FULL_DUTY;
               nxt.wait_count  = wait_for(high_t);
            end
            PHASE_FALL: begin
               nxt.shown_level = fall_duty;
               nxt.wait_count  = wait_for(step_t);
            end
            default: begin
               nxt.shown_level = ZERO_DUTY;
               nxt.wait_count  = '0;
            end
         endcase
      end
   end

endmodule

### rtl/led_breathing_pattern_generator.sv
// ----------------------------------------------------------------------------
// led_breathing_pattern_generator
// Tick-driven LED breathing sequencer: low, rise, high, fall, one duty level
// per tick transaction, with four programmable pattern words.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_stall  | selected_pattern[2:0]
//   rsp     | out       | rsp_valid/rsp_stall  | brightness[6:0], phase, active
//   csr     | in        | csr_write            | csr_index[2:0], csr_wdata[63:0]
//
// One tick per cycle while not stalled; result shown the cycle after accept.
// The whole per-tick update (wait decrement, or one add/compare on duty) sits
// between the state registers and the output register.
// Synchronous active-high reset clears the pattern words, sequencer state and
// rsp_valid. req_stall is raised only while a result is held under rsp_stall;
// a result that is taken in the same cycle frees the slot for the next tick.
//
module led_breathing_pattern_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   // tick input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lbpg_pkg::PAT_BITS-1:0]         req_selected_pattern,
   // brightness output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lbpg_pkg::DUTY_BITS-1:0]        rsp_brightness,
   output logic [1:0]                            rsp_phase,
   output logic                                  rsp_active,
   // configuration writes
   input  logic                                  csr_write,
   input  logic [lbpg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lbpg_pkg::WORD_BITS-1:0]        csr_wdata
);
   import lbpg_pkg::*;

   logic [WORD_BITS-1:0] word_ff [NUM_WORDS];
   logic [WORD_BITS-1:0] sel_word;
   state_type            state_ff;
   state_type            state_in;
   logic                 active_ff;
   logic                 active_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 req_accept;
   logic                 rsp_accept;

   // Pattern words; writes beyond the last word are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) word_ff[i] <= '0;
      end else if (csr_write && (csr_index < CSR_INDEX_BITS'(NUM_WORDS))) begin
         word_ff[csr_index[WORD_IDX_BITS-1:0]] <= csr_wdata;
      end
   end

   // Pattern numbers without a word select an all-zero word
   assign sel_word = (req_selected_pattern < PAT_BITS'(NUM_WORDS))
                   ? word_ff[req_selected_pattern[WORD_IDX_BITS-1:0]] : '0;

   // Handshake: single output slot, refilled in the cycle it drains
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   lbpg_step u_step (
      .cur     (state_ff),
      .pattern (req_selected_pattern),
      .word    (sel_word),
      .nxt     (state_in)
   );

   assign active_in    = (state_in.last_pattern < PAT_BITS'(NUM_PATTERNS));
   assign rsp_valid_in = req_accept ? 1'b1 : (rsp_accept ? 1'b0 : rsp_valid_ff);

   // State and shown values only move on an accepted tick, so the response
   // payload holds while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= PHASE_LOW;
         state_ff.duty         <= ZERO_DUTY;
         state_ff.wait_count   <= '0;
         state_ff.last_pattern <= NO_PATTERN;
         state_ff.shown_level  <= ZERO_DUTY;
         state_ff.shown_phase  <= PHASE_LOW;
         active_ff             <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff  <= state_in;
            active_ff <= active_in;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_brightness = state_ff.shown_level;
   assign rsp_phase      = state_ff.shown_phase;
   assign rsp_active     = active_ff;

   // ---- assertions ----
   // High phase is only reached once duty saturates at full
   a_high_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PHASE_HIGH) |-> (state_ff.duty == FULL_DUTY))
      else $error("high phase pending without full duty");

   // Fall phase ending at zero always hands over to low
   a_fall_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PHASE_FALL) |-> (state_ff.duty != ZERO_DUTY))
      else $error("fall phase pending with zero duty");

   // Shown level agrees with shown phase on the plateau phases
   a_shown_plateau: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_phase == PHASE_HIGH && rsp_brightness != FULL_DUTY) ||
                    (rsp_phase == PHASE_LOW && rsp_brightness != ZERO_DUTY)) |-> 1'b0)
      else $error("shown level disagrees with shown phase");

   // A tick that lands in a wait leaves every output field unchanged
   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && state_ff.wait_count != '0) |=>
         ($stable(rsp_brightness) && $stable(rsp_phase) && $stable(rsp_active)))
      else $error("outputs moved during a wait");

   // No-pattern code deactivates and arms no wait
   a_no_pattern: assert property (@(posedge clock) disable iff (reset)
      (req_accept && state_ff.wait_count == '0 &&
       req_selected_pattern >= PAT_BITS'(NUM_PATTERNS)) |=>
         (!rsp_active && state_ff.wait_count == '0))
      else $error("no-pattern tick left block active or waiting");

endmodule

### dv/tb_led_breathing_pattern_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_breathing_pattern_generator
// Self-checking bench for the LED breathing sequencer. A tick driver feeds
// pattern numbers, a tick-level predictor tracks the low/rise/high/fall
// sequence, and a monitor compares every brightness transaction against it.
// ----------------------------------------------------------------------------
module tb_led_breathing_pattern_generator;
   import lbpg_pkg::*;

   // CSR map: pattern word p sits at index p, the rest is unmapped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI       = 3'd7;

   localparam int RANDOM_PHASES    = 8;
   localparam int TICKS_PER_PHASE  = 85;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 8;

   // One expected brightness transaction
   typedef struct {
      logic [DUTY_BITS-1:0] brightness;
      phase_type            phase;
      logic                 active;
   } led_level_type;

   typedef struct {
      logic [CSR_INDEX_BITS-1:0] index;
      logic [WORD_BITS-1:0]      data;
   } csr_write_type;

   // ------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                      clock;
   logic                      reset                = 1'b1;
   logic                      req_valid            = 1'b0;
   logic                      req_stall;
   logic [PAT_BITS-1:0]       req_selected_pattern = NO_PATTERN;
   logic                      rsp_valid;
   logic                      rsp_stall            = 1'b0;
   logic [DUTY_BITS-1:0]      rsp_brightness;
   logic [1:0]                rsp_phase;
   logic                      rsp_active;
   logic                      csr_write            = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index            = '0;
   logic [WORD_BITS-1:0]      csr_wdata            = '0;

   led_breathing_pattern_generator u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_selected_pattern (req_selected_pattern),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_brightness       (rsp_brightness),
      .rsp_phase            (rsp_phase),
      .rsp_active           (rsp_active),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   logic [PAT_BITS-1:0] tick_queue[$];       // patterns waiting to be driven
   led_level_type       predicted_levels[$]; // levels owed by the DUT
   csr_write_type       csr_pending[$];

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int holds_requested = 0;
   int holds_served    = 0;
   int hold_left       = 0;

   int ticks_queued   = 0;
   int ticks_sent     = 0;
   int levels_checked = 0;
   int csr_writes     = 0;
   int phases_run     = 0;
   int mismatches     = 0;

   // ------------------------------------------------------------------------
   // Breathing predictor: its own copy of the pattern words and sequencer
   // ------------------------------------------------------------------------
   logic [WORD_BITS-1:0] pat_word[NUM_WORDS];
   phase_type            seq_phase;     // next phase to run
   int unsigned          seq_duty;      // wide so rise overflow can be clamped
   logic [TIME_BITS-1:0] seq_wait;
   logic [PAT_BITS-1:0]  seq_pattern;
   logic [DUTY_BITS-1:0] lit_level;     // registers behind the outputs
   phase_type            lit_phase;

   function automatic logic [TIME_BITS-1:0] ticks_to_wait(input logic [TIME_BITS-1:0] t);
      // zero and one both let the very next tick act
      return (t == '0) ? '0 : t - TIME_BITS'(1);
   endfunction

   function automatic logic [WORD_BITS-1:0] pack_word(input logic [TIME_BITS-1:0] low_t,
                                                      input logic [TIME_BITS-1:0] high_t,
                                                      input logic [7:0] step_t,
                                                      input logic [7:0] rate);
      return {rate, step_t, high_t, low_t};
   endfunction

   // Advance the sequencer by one tick and queue the level it shows
   function automatic void breathe_tick(input logic [PAT_BITS-1:0] pat);
      logic [WORD_BITS-1:0] w;
      logic [TIME_BITS-1:0] low_t, high_t;
      logic [7:0]           step_t, rate;
      led_level_type        lvl;
      w = '0;
      if (seq_wait != '0) begin
         // waiting: count down only, outputs hold, pattern not sampled
         seq_wait = seq_wait - TIME_BITS'(1);
      end else begin
         if (pat != seq_pattern) begin
            seq_pattern = pat;
            seq_phase   = PHASE_LOW;
            seq_duty    = 0;
         end
         if (pat < NUM_PATTERNS) begin
            if (pat < NUM_WORDS)
               w = pat_word[pat[WORD_IDX_BITS-1:0]];
            low_t     = w[TIME_BITS-1:0];
            high_t    = w[HIGH_LSB +: TIME_BITS];
            step_t    = w[STEP_LSB +: BYTE_BITS];
            rate      = w[RATE_LSB +: BYTE_BITS];
            lit_phase = seq_phase;
            case (seq_phase)
               PHASE_LOW: begin
                  lit_level = ZERO_DUTY;
                  seq_phase = PHASE_RISE;
                  seq_wait  = ticks_to_wait(low_t);
               end
               PHASE_RISE: begin
                  seq_duty = seq_duty + 32'(rate);
                  if (seq_duty >= 32'(FULL_DUTY)) begin
                     seq_duty  = 32'(FULL_DUTY);
                     seq_phase = PHASE_HIGH;
                  end
                  lit_level = DUTY_BITS'(seq_duty);
                  seq_wait  = ticks_to_wait(TIME_BITS'(step_t));
               end
               PHASE_HIGH: begin
                  lit_level = FULL_DUTY;
                  seq_phase = PHASE_FALL;
                  seq_wait  = ticks_to_wait(high_t);
               end
               default: begin
                  seq_duty = (seq_duty > 32'(rate)) ? seq_duty - 32'(rate) : 0;
                  if (seq_duty == 0)
                     seq_phase = PHASE_LOW;
                  lit_level = DUTY_BITS'(seq_duty);
                  seq_wait  = ticks_to_wait(TIME_BITS'(step_t));
               end
            endcase
         end
      end
      lvl.brightness = lit_level;
      lvl.phase      = lit_phase;
      lvl.active     = (seq_pattern < NUM_PATTERNS);
      predicted_levels.push_back(lvl);
   endfunction

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Tick driver: offers the next queued pattern, holds it while stalled.
   // The prediction is made at the edge where the transaction is accepted.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : tick_driver
      logic send_now;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            breathe_tick(req_selected_pattern);
            ticks_sent++;
         end
         if (!req_valid || !req_stall) begin
            send_now = (tick_queue.size() != 0) &&
                       !(sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct);
            if (send_now) begin
               req_valid            <= 1'b1;
               req_selected_pattern <= tick_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver back-pressure: random stalls, plus a long hold-off on request
   // that lets the DUT fill up and push back on the tick side.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_requested) begin
         rsp_stall    <= 1'b1;
         hold_left    <= LONG_HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every accepted brightness transaction against the oldest level
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : level_monitor
      led_level_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_levels.size() == 0) begin
            $error("unexpected transaction: brightness %0d phase %0d active %0d",
                   rsp_brightness, rsp_phase, rsp_active);
            mismatches++;
         end else begin
            want = predicted_levels.pop_front();
            levels_checked++;
            if (rsp_brightness !== want.brightness) begin
               $error("brightness: expected %0d, got %0d", want.brightness, rsp_brightness);
               mismatches++;
            end
            if (rsp_phase !== want.phase) begin
               $error("phase: expected %0d, got %0d", want.phase, rsp_phase);
               mismatches++;
            end
            if (rsp_active !== want.active) begin
               $error("active: expected %0d, got %0d", want.active, rsp_active);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void queue_tick(input logic [PAT_BITS-1:0] pat, input int count);
      repeat (count) begin
         tick_queue.push_back(pat);
         ticks_queued++;
      end
   endfunction

   // Mostly runs of one pattern long enough to breathe, some off stretches,
   // some single-tick noise that forces restarts.
   function automatic void queue_breathing_runs(input int n_ticks);
      int target, roll;
      target = ticks_queued + n_ticks;
      while (ticks_queued < target) begin
         roll = $urandom_range(99);
         if (roll < 78)
            queue_tick(PAT_BITS'($urandom_range(NUM_PATTERNS - 1)), $urandom_range(40, 8));
         else if (roll < 90)
            queue_tick(NO_PATTERN, $urandom_range(5, 1));
         else
            queue_tick(PAT_BITS'($urandom_range(NO_PATTERN)), 1);
      end
   endfunction

   // Short waits most of the time so whole breathing cycles fit in a run
   function automatic logic [WORD_BITS-1:0] random_pattern_word();
      logic [TIME_BITS-1:0] low_t, high_t;
      logic [7:0]           step_t, rate;
      low_t  = ($urandom_range(15) == 0) ? TIME_BITS'($urandom_range(40, 5))
                                          : TIME_BITS'($urandom_range(4));
      high_t = ($urandom_range(15) == 0) ? TIME_BITS'($urandom_range(40, 5))
                                          : TIME_BITS'($urandom_range(4));
      step_t = ($urandom_range(31) == 0) ? 8'($urandom_range(20, 5))
                                          : 8'($urandom_range(3));
      case ($urandom_range(15))
         0:       rate = 8'd0;
         1:       rate = 8'hFF;
         2:       rate = 8'd100;
         3:       rate = 8'd99;
         default: rate = 8'($urandom_range(60, 1));
      endcase
      return pack_word(low_t, high_t, step_t, rate);
   endfunction

   function automatic void queue_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [WORD_BITS-1:0] data);
      csr_write_type wr;
      wr.index = idx;
      wr.data  = data;
      csr_pending.push_back(wr);
   endfunction

   // Back-to-back register writes; the DUT is idle, so the predictor copy is
   // updated as each write is driven.
   task automatic flush_csr_writes();
      csr_write_type wr;
      while (csr_pending.size() != 0) begin
         wr = csr_pending.pop_front();
         csr_write <= 1'b1;
         csr_index <= wr.index;
         csr_wdata <= wr.data;
         if (wr.index < NUM_WORDS)
            pat_word[wr.index[WORD_IDX_BITS-1:0]] = wr.data;
         csr_writes++;
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // Returns at a rising edge once every tick is accepted and answered
   task automatic wait_drained();
      do
         @(posedge clock);
      while (ticks_sent != ticks_queued || predicted_levels.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < NUM_WORDS; i++)
         pat_word[i] = '0;
      seq_phase   = PHASE_LOW;
      seq_duty    = 0;
      seq_wait    = '0;
      seq_pattern = NO_PATTERN;
      lit_level   = ZERO_DUTY;
      lit_phase   = PHASE_LOW;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset words are all zero: off tick, then rate 0 parks in rise at 0
      queue_tick(NO_PATTERN, 1);
      queue_tick(PAT_BITS'(0), 2);
      wait_drained();
      phases_run++;

      // Directed words:
      //   0: ordinary breath, rate 40 (rise clamps on the third step)
      //   1: rate 255, zero times - one-step clamp to full and to off
      //   2: rate 0, stuck in rise for ever
      //   3: rate exactly 100
      // Unmapped indexes are written last so an aliased decode shows up.
      queue_csr(CSR_PATTERN_WORD_0, pack_word(24'd2, 24'd3, 8'd1, 8'd40));
      queue_csr(CSR_INDEX_BITS'(CSR_PATTERN_WORD_0 + 1), pack_word(24'd0, 24'd0, 8'd0, 8'hFF));
      queue_csr(CSR_INDEX_BITS'(CSR_PATTERN_WORD_0 + 2), pack_word(24'd1, 24'd0, 8'd2, 8'd0));
      queue_csr(CSR_PATTERN_WORD_3, pack_word(24'd0, 24'd1, 8'd1, 8'd100));
      queue_csr(CSR_SPARE_LO, '1);
      queue_csr(CSR_SPARE_HI, {32'h5555_5555, 32'hAAAA_AAAA});
      flush_csr_writes();
      queue_tick(PAT_BITS'(0), 10);
      queue_tick(PAT_BITS'(1), 5);
      queue_tick(PAT_BITS'(2), 3);
      queue_tick(NO_PATTERN, 2);   // outputs hold, active drops
      queue_tick(PAT_BITS'(3), 4);
      wait_drained();
      phases_run++;

      // Random phases, rotating through the idling mixes
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         for (int i = 0; i < NUM_WORDS; i++)
            queue_csr(CSR_INDEX_BITS'(CSR_PATTERN_WORD_0 + i), random_pattern_word());
         flush_csr_writes();
         case (k % 4)
            0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
            1:       begin sender_idle_pct = 87; stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  stall_pct = 87; end
            default: begin sender_idle_pct = 23; stall_pct = 23; end
         endcase
         // one long receiver hold-off while ticks keep coming at full rate
         if (k == 4)
            holds_requested++;
         queue_breathing_runs(TICKS_PER_PHASE);
         wait_drained();
         phases_run++;
      end

      // Extremes: all-zero word and all-ones word (maximum low time, so the
      // sequencer sits in one long wait once pattern 3 is sampled)
      sender_idle_pct = 23;
      stall_pct       = 23;
      queue_csr(CSR_INDEX_BITS'(CSR_PATTERN_WORD_0 + 2), '0);
      queue_csr(CSR_PATTERN_WORD_3, '1);
      flush_csr_writes();
      queue_tick(PAT_BITS'(2), 4);
      queue_tick(PAT_BITS'(3), 60);
      wait_drained();
      phases_run++;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_levels.size() != 0) begin
         $error("%0d brightness transactions never arrived", predicted_levels.size());
         mismatches++;
      end

      $display("Covered %0d tick transactions in %0d phases, %0d levels compared,",
               ticks_sent, phases_run, levels_checked);
      $display("%0d register writes incl. unmapped indexes, %0d long receiver hold-off(s).",
               csr_writes, holds_served);
      if (mismatches == 0)
         $display("tb_led_breathing_pattern_generator OK");
      else
         $display("tb_led_breathing_pattern_generator NOT OK");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb_led_breathing_pattern_generator NOT OK");
      $finish;
   end

endmodule
